@@ hdl/bba_pkg.sv @@
// Package: sizes, codes and memory request type of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int MAP_BYTES     = 128;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_W         = 3;
  localparam int TOTAL_BLOCKS  = MAP_BYTES * BITS_PER_BYTE;
  localparam int ADDR_W        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int BLK_W         = ADDR_W + BIT_W;
  localparam int FREE_W        = $clog2(TOTAL_BLOCKS + 1);
  localparam int IDX_W         = 10;
  localparam int CNT_OUT_W     = 11;
  localparam int CMP_W         = (FREE_W > IDX_W) ? FREE_W : IDX_W + 1;

  typedef logic [BITS_PER_BYTE-1:0] map_byte_t;

  localparam map_byte_t FULL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_BAD   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAME = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    map_byte_t         wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

@@ hdl/bba_bitmap_store.sv @@
// Bitmap memory with per-byte valid bits: an unwritten byte reads as all free.
`default_nettype none

module bba_bitmap_store (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bba_pkg::mem_req_t   req,
  output bba_pkg::map_byte_t       rd_data
);

  bba_pkg::map_byte_t                mem [bba_pkg::MAP_BYTES];
  bba_pkg::map_byte_t                mem_q;
  logic [bba_pkg::MAP_BYTES-1:0]     valid_r;
  logic                              hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = hit_r ? mem_q : '0;

endmodule

`default_nettype wire

@@ hdl/bitmap_block_allocator_core.sv @@
// Top level: free-block bitmap allocator with byte-wide scan and read-modify-write.
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+-------------------
//  input   | in_action, in_block_index                          | start && !busy
//  result  | out_status, out_result_index, out_free_count       | out_valid strobe
//
//  Mark used / mark free: read the byte, then write it back if the bit changes.
//  Allocate: scans bytes from address 0 up to the first non-full one
//  (at most MAP_BYTES); one byte per cycle through the single memory read port.
//  Errors (bad action, index out of range, map full) strobe in the cycle after accept.
//  Reset clears the byte valid bits and sets the free count to TOTAL_BLOCKS; no clearing pass.
//  The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none

module bitmap_block_allocator_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_action,
  input  wire logic [bba_pkg::IDX_W-1:0]      in_block_index,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [bba_pkg::IDX_W-1:0]           out_result_index,
  output logic [bba_pkg::CNT_OUT_W-1:0]       out_free_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_SCAN
  } state_t;

  localparam logic [bba_pkg::ADDR_W-1:0] LAST_ADDR = bba_pkg::ADDR_W'(bba_pkg::MAP_BYTES - 1);
  localparam logic [bba_pkg::FREE_W-1:0] TOTAL_CNT = bba_pkg::FREE_W'(bba_pkg::TOTAL_BLOCKS);

  state_t                            state_r;
  bba_pkg::action_t                  act_r;
  logic [bba_pkg::IDX_W-1:0]         idx_r;
  logic [bba_pkg::ADDR_W-1:0]        scan_addr_r;
  logic [bba_pkg::FREE_W-1:0]        free_r;
  logic                              out_valid_r;
  bba_pkg::status_t                  out_status_r;
  logic [bba_pkg::IDX_W-1:0]         out_index_r;
  logic [bba_pkg::CNT_OUT_W-1:0]     out_free_r;

  bba_pkg::action_t                  act;
  logic                              in_range;
  logic [bba_pkg::BLK_W-1:0]         blk_in;
  logic [bba_pkg::BLK_W-1:0]         blk_r;
  logic [bba_pkg::BIT_W-1:0]         zero_pos;
  logic [bba_pkg::BLK_W-1:0]         alloc_blk;
  bba_pkg::map_byte_t                mark_mask;
  bba_pkg::map_byte_t                rd_data;
  logic                              mark_same;
  logic                              byte_full;
  logic [bba_pkg::FREE_W-1:0]        free_dec;
  logic [bba_pkg::FREE_W-1:0]        free_inc;
  bba_pkg::mem_req_t                 req;

  assign act       = bba_pkg::action_t'(in_action);
  assign in_range  = bba_pkg::CMP_W'(in_block_index) < bba_pkg::CMP_W'(bba_pkg::TOTAL_BLOCKS);
  assign blk_in    = bba_pkg::BLK_W'(in_block_index);
  assign blk_r     = bba_pkg::BLK_W'(idx_r);
  assign mark_mask = bba_pkg::map_byte_t'(1) << blk_r[bba_pkg::BIT_W-1:0];
  assign mark_same = ((rd_data & mark_mask) != '0) == (act_r == bba_pkg::ACT_SET);
  assign byte_full = (rd_data == bba_pkg::FULL_BYTE);
  assign alloc_blk = {scan_addr_r, zero_pos};
  assign free_dec  = (free_r != '0) ? free_r - bba_pkg::FREE_W'(1) : free_r;
  assign free_inc  = (free_r < TOTAL_CNT) ? free_r + bba_pkg::FREE_W'(1) : free_r;

  always_comb begin
    zero_pos = '0;
    for (int k = bba_pkg::BITS_PER_BYTE - 1; k >= 0; k--) begin
      if (!rd_data[k]) begin
        zero_pos = bba_pkg::BIT_W'(k);
      end
    end
  end

  always_comb begin
    req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (act == bba_pkg::ACT_ALLOC && free_r != '0) begin
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
          end else if ((act == bba_pkg::ACT_SET || act == bba_pkg::ACT_CLEAR) && in_range) begin
            req.rd_en   = 1'b1;
            req.rd_addr = blk_in[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
          end
        end
      end
      S_MARK: begin
        req.wr_en   = !mark_same;
        req.wr_addr = blk_r[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
        req.wr_data = (act_r == bba_pkg::ACT_SET) ? (rd_data | mark_mask)
                                                  : (rd_data & ~mark_mask);
      end
      S_SCAN: begin
        req.rd_en   = byte_full && (scan_addr_r != LAST_ADDR);
        req.rd_addr = scan_addr_r + bba_pkg::ADDR_W'(1);
        req.wr_en   = !byte_full;
        req.wr_addr = scan_addr_r;
        req.wr_data = rd_data | (bba_pkg::map_byte_t'(1) << zero_pos);
      end
      default: req = '0;
    endcase
  end

  bba_bitmap_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= TOTAL_CNT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            act_r       <= act;
            idx_r       <= in_block_index;
            scan_addr_r <= '0;
            out_free_r  <= bba_pkg::CNT_OUT_W'(free_r);
            priority if (act == bba_pkg::ACT_BAD) begin
              out_valid_r  <= 1'b1;
              out_status_r <= bba_pkg::ST_ERR;
              out_index_r  <= '0;
            end else if (act == bba_pkg::ACT_ALLOC) begin
              if (free_r == '0) begin
                out_valid_r  <= 1'b1;
                out_status_r <= bba_pkg::ST_ERR;
                out_index_r  <= '0;
              end else begin
                state_r <= S_SCAN;
              end
            end else if (!in_range) begin
              out_valid_r  <= 1'b1;
              out_status_r <= bba_pkg::ST_ERR;
              out_index_r  <= in_block_index;
            end else begin
              state_r <= S_MARK;
            end
          end
        end
        S_MARK: begin
          out_valid_r <= 1'b1;
          out_index_r <= idx_r;
          state_r     <= S_IDLE;
          if (mark_same) begin
            out_status_r <= bba_pkg::ST_SAME;
            out_free_r   <= bba_pkg::CNT_OUT_W'(free_r);
          end else if (act_r == bba_pkg::ACT_SET) begin
            out_status_r <= bba_pkg::ST_OK;
            free_r       <= free_dec;
            out_free_r   <= bba_pkg::CNT_OUT_W'(free_dec);
          end else begin
            out_status_r <= bba_pkg::ST_OK;
            free_r       <= free_inc;
            out_free_r   <= bba_pkg::CNT_OUT_W'(free_inc);
          end
        end
        S_SCAN: begin
          if (!byte_full) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bba_pkg::ST_OK;
            out_index_r  <= bba_pkg::IDX_W'(alloc_blk);
            free_r       <= free_dec;
            out_free_r   <= bba_pkg::CNT_OUT_W'(free_dec);
            state_r      <= S_IDLE;
          end else if (scan_addr_r == LAST_ADDR) begin
            out_valid_r  <= 1'b1;
            out_status_r <= bba_pkg::ST_ERR;
            out_index_r  <= '0;
            out_free_r   <= bba_pkg::CNT_OUT_W'(free_r);
            state_r      <= S_IDLE;
          end else begin
            scan_addr_r <= scan_addr_r + bba_pkg::ADDR_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;
  assign out_free_count   = out_free_r;

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && out_valid))
    else $error("result strobe while a request is in progress");

  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without a transaction");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= TOTAL_CNT)
    else $error("free count above total blocks");

  a_mark_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> $past(state_r == S_IDLE && start))
    else $error("mark state entered without an accepted transaction");

endmodule

`default_nettype wire
